// File: rtl/spq_pkg.sv
package spq_pkg;

    localparam int SPQ_DEPTH = 16;
    localparam int DATA_W    = 32;
    localparam int PRIO_W    = 16;
    localparam int FILL_W    = 5;

    typedef enum logic
    {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } req_kind_t;

    typedef enum logic [1:0]
    {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        req_kind_t                 req_type;
        logic signed [DATA_W-1:0]  in_data;
        logic        [PRIO_W-1:0]  in_priority;
    } req_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0]  out_data;
        logic        [PRIO_W-1:0]  out_priority;
        status_t                   status;
        logic        [FILL_W-1:0]  fill_level;
    } rsp_t;

    // Broadcast to every cell: the operation that applies this cycle.
    typedef struct packed
    {
        logic                      ins;
        logic                      del;
        logic signed [DATA_W-1:0]  data;
        logic        [PRIO_W-1:0]  prio;
    } spq_cmd_t;

    // What a cell shows its neighbours.
    typedef struct packed
    {
        logic                      occupied;
        logic                      go;       // occupied and priority above the new one
        logic signed [DATA_W-1:0]  data;
        logic        [PRIO_W-1:0]  prio;
    } spq_link_t;

    // Left of cell 0: looks held and never moves, so cell 0 may take a new item.
    localparam spq_link_t LINK_HEAD = '{occupied: 1'b1, go: 1'b0, data: '0, prio: '0};
    // Right of the last cell: empty.
    localparam spq_link_t LINK_TAIL = '{occupied: 1'b0, go: 1'b0, data: '0, prio: '0};

endpackage

// File: rtl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  spq_cmd_t  cmd,
    input  spq_link_t left,
    input  spq_link_t right,
    output spq_link_t self
);

    logic                     occupied_reg, occupied_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic        [PRIO_W-1:0] prio_reg, prio_next;
    logic                     go;

    assign go = occupied_reg && (prio_reg > cmd.prio);

    always_comb
    begin
        occupied_next = occupied_reg;
        data_next     = data_reg;
        prio_next     = prio_reg;
        if (cmd.ins)
        begin
            if (left.go)
            begin
                // shift right to open the slot
                occupied_next = left.occupied;
                data_next     = left.data;
                prio_next     = left.prio;
            end
            else if (go || (!occupied_reg && left.occupied))
            begin
                occupied_next = 1'b1;
                data_next     = cmd.data;
                prio_next     = cmd.prio;
            end
        end
        else if (cmd.del)
        begin
            occupied_next = right.occupied;
            data_next     = right.data;
            prio_next     = right.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign self = '{occupied: occupied_reg, go: go, data: data_reg, prio: prio_reg};

endmodule

// File: rtl/sorted_priority_queue_core.sv
// Channel  Valid      Stall      Payload  Moves
// -------  ---------  ---------  -------  ------------------------------------
// request  req_valid  req_stall  req      insert or delete request in
// result   rsp_valid  rsp_stall  rsp      one result per request out
//
// One request per cycle while req_stall is low: every cell compares against
// the new priority and shifts in the same cycle.
// A result appears in the cycle after its request is taken, from an output register.
// req_stall is high only while that register holds a result still stalled.
// Reset empties the queue at once (occupancy flags only); no clearing pass.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = SPQ_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_link_t        lnk [DEPTH];
    logic [DEPTH-1:0] occ;
    spq_cmd_t         cmd;

    logic             accept;
    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_del;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W+FILL_W-1:0] cnt_ext;
    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;

    // ---------------------------------------------------------------
    // Handshake: take a request whenever the output register is free
    // or is being emptied in this cycle.
    // ---------------------------------------------------------------
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign full   = occ[DEPTH-1];
    assign empty  = !occ[0];
    assign do_ins = accept && (req.req_type == REQ_INSERT) && !full;
    assign do_del = accept && (req.req_type == REQ_DELETE) && !empty;

    assign cmd = '{ins: do_ins, del: do_del, data: req.in_data, prio: req.in_priority};

    // ---------------------------------------------------------------
    // Chain of cells, sorted by ascending priority from cell 0.
    // ---------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_link_t left_l;
        spq_link_t right_l;

        if (i == 0)
        begin : g_head
            assign left_l = LINK_HEAD;
        end
        else
        begin : g_mid_l
            assign left_l = lnk[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_l = LINK_TAIL;
        end
        else
        begin : g_mid_r
            assign right_l = lnk[i+1];
        end

        spq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_l),
            .right (right_l),
            .self  (lnk[i])
        );

        assign occ[i] = lnk[i].occupied;
    end

    // ---------------------------------------------------------------
    // Fill count and result register.
    // ---------------------------------------------------------------
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_ins)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_del)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // fill_level carries the low bits of the count
    assign cnt_ext = {{FILL_W{1'b0}}, cnt_next};

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.status       = ST_DONE;
        rsp_next.fill_level   = cnt_ext[FILL_W-1:0];
        if (req.req_type == REQ_DELETE)
        begin
            if (empty)
            begin
                rsp_next.status = ST_EMPTY;
            end
            else
            begin
                rsp_next.out_data     = lnk[0].data;
                rsp_next.out_priority = lnk[0].prio;
            end
        end
        else if (full)
        begin
            rsp_next.status = ST_FULL;
        end
    end

    assign rsp_valid_next = accept || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // occupancy flags and the count agree
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ) == cnt_reg)
        else $error("cell occupancy differs from count");

    // the head pair stays in order
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        occ[1] |-> (lnk[0].prio <= lnk[1].prio))
        else $error("head cells out of order");

    // a refused insert reports full
    a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_INSERT && full) |=> (rsp.status == ST_FULL))
        else $error("insert on full queue not flagged");

    // a delete on a held queue removes exactly one entry
    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_del |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("delete did not drop the count by one");

endmodule

// File: test/spq_order_checker.sv
module spq_order_checker
    import spq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    // Own copy of the queue contents, sorted by ascending priority value.
    logic signed [DATA_W-1:0] held_data [SPQ_DEPTH];
    logic        [PRIO_W-1:0] held_prio [SPQ_DEPTH];
    int                       held_count;

    rsp_t due_results [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
        held_count = 0;
    end

    // Applies one request to the queue copy and returns the result it should give.
    function automatic rsp_t apply_request(req_t r);
        rsp_t res;
        int   slot;
        res        = '0;
        res.status = ST_DONE;
        if (r.req_type == REQ_INSERT)
        begin
            if (held_count >= SPQ_DEPTH)
                res.status = ST_FULL;
            else
            begin
                // lands behind every entry of equal or lower priority value
                slot = held_count;
                while (slot > 0 && held_prio[slot-1] > r.in_priority)
                begin
                    held_data[slot] = held_data[slot-1];
                    held_prio[slot] = held_prio[slot-1];
                    slot--;
                end
                held_data[slot] = r.in_data;
                held_prio[slot] = r.in_priority;
                held_count++;
            end
        end
        else if (held_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.out_data     = held_data[0];
            res.out_priority = held_prio[0];
            for (int i = 1; i < held_count; i++)
            begin
                held_data[i-1] = held_data[i];
                held_prio[i-1] = held_prio[i];
            end
            held_count--;
        end
        res.fill_level = FILL_W'(held_count);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            held_count = 0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            // results first: a request taken this edge cannot answer before the next
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.out_data !== want.out_data)
                    begin
                        $error("out_data: expected %0d, got %0d", want.out_data, rsp.out_data);
                        fail_count++;
                    end
                    if (rsp.out_priority !== want.out_priority)
                    begin
                        $error("out_priority: expected %0d, got %0d",
                               want.out_priority, rsp.out_priority);
                        fail_count++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.fill_level !== want.fill_level)
                    begin
                        $error("fill_level: expected %0d, got %0d",
                               want.fill_level, rsp.fill_level);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                due_results.push_back(apply_request(req));
            pending = due_results.size();
        end
    end

endmodule

// File: test/tb_sorted_priority_queue_core.sv
module tb_sorted_priority_queue_core
    import spq_pkg::*;
();

    localparam int RANDOM_REQUESTS = 1580;
    localparam int PHASE_LEN       = 40;    // requests per insert/delete mix phase
    localparam int HOLD_CYCLES     = 150;   // long result hold-off
    localparam int CYCLE_LIMIT     = 600000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;

    // Shared between stimulus and the result-side stall process.
    bit   burst    = 1'b0;  // sender offers back to back while set
    bit   hold_due = 1'b0;  // asks the result side for a long hold-off

    always #5 clk = ~clk;

    sorted_priority_queue_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    spq_order_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // Priorities: a narrow band makes plenty of ties, the wide ones exercise every bit.
    function automatic logic [PRIO_W-1:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return PRIO_W'($urandom_range(0, 7));
        if (r < 75)
            return PRIO_W'($urandom_range(0, 255));
        if (r < 95)
            return PRIO_W'($urandom_range(0, 65535));
        if (r < 97)
            return '0;
        return '1;
    endfunction

    // Offers one request and returns at the edge where it is taken.
    // valid is only dropped when an idle gap follows, so it never
    // gets two nonblocking updates in one step.
    task automatic send_request(input req_kind_t kind,
                                input logic signed [DATA_W-1:0] data,
                                input logic [PRIO_W-1:0] prio);
        req_t r;
        int   gap;
        r.req_type    = kind;
        r.in_data     = data;
        r.in_priority = prio;
        gap = burst ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Result side: runs of acceptance broken by stalls, plus the long
    // hold-off on request so the output register backs up into req_stall
    // while the sender keeps offering requests.
    initial
    begin
        int run;
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_due)
            begin
                hold_due = 1'b0;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            // occasionally a long stretch with no stall at all
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Watchdog: anything left outstanding ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int        ins_pct;
        req_kind_t kind;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Delete on an empty queue.
        send_request(REQ_DELETE, 32'sd0, 16'd0);
        // Extremes of data and priority, ties at both ends of the priority range.
        send_request(REQ_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
        send_request(REQ_INSERT, 32'sh8000_0000, 16'h0000);
        send_request(REQ_INSERT, -32'sd1,        16'h0000);
        send_request(REQ_INSERT, 32'sd0,         16'h8000);
        send_request(REQ_INSERT, 32'sd1,         16'h0001);
        send_request(REQ_INSERT, -32'sd2,        16'hFFFF);
        send_request(REQ_INSERT, 32'sh5555_5555, 16'h7FFF);
        send_request(REQ_INSERT, 32'shAAAA_AAAA, 16'h0005);
        // Fill up the rest with a few small priorities that repeat.
        for (int i = 0; i < 8; i++)
            send_request(REQ_INSERT, DATA_W'(i * 32'h1111_1111), PRIO_W'(i % 3 + 4));
        // Insert on a full queue is refused.
        send_request(REQ_INSERT, 32'sh1234_5678, 16'h0000);
        send_request(REQ_DELETE, 32'sh0BAD_0BAD, 16'hFFFF);
        send_request(REQ_DELETE, 32'sd0, 16'd0);

        // Random part: phases that lean towards filling, draining or a mix,
        // so the queue keeps hitting both full and empty.
        ins_pct = 50;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       ins_pct = 85;
                    1:       ins_pct = 15;
                    default: ins_pct = 50;
                endcase
                burst = ($urandom_range(0, 3) == 0);
            end
            if (n == 300 || n == 1100)
                hold_due = 1'b1;
            kind = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_DELETE;
            send_request(kind, $urandom, pick_prio());
        end
        req_valid <= 1'b0;

        // Drain: let the checker book the last request, wait until everything
        // is answered, then leave room for anything stray.
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
